@@ rtl/apq_pkg.sv @@
package apq_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int PRIO_W    = 16;
  localparam int ITEM_W    = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [PRIO_W-1:0]        priority_req;
    logic signed [ITEM_W-1:0] item_in;
  } in_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0] item_out;
    logic [1:0]               status;
  } out_t;

  // one stored slot: priority and item side by side in the memory
  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [ITEM_W-1:0] item;
  } slot_t;

  // control from the sequencer to the running-maximum unit
  typedef struct packed {
    logic clr;
    logic cmp;
  } best_ctl_t;

endpackage

@@ rtl/array_priority_queue_unit.sv @@
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data  (op, priority_req, item_in)
// out     | output    | out_valid/out_stall| out_data (item_out, status)
//
// Remove/peek: the slots are read one per cycle through the single memory read port
// and the shared comparator, then the read pipeline drains before the result is taken.
// Insert: the valid bits are tested one per cycle from slot 0 up to the lowest free slot.
// Full insert, empty remove/peek and unused op codes go straight to the result.
// Synchronous reset empties the queue; slot memory contents are not cleared.
// in_stall is high from accept until the result is in the output register;
// a stalled result is held while the next item is taken.
module array_priority_queue_unit #(
  parameter int SLOTS = apq_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  apq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output apq_pkg::out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FREE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    entry_count;
  logic [SLOTS-1:0] slot_valid;
  apq_pkg::in_t     req;
  apq_pkg::out_t    res;
  logic             rd_pend;
  logic             rd_vld;
  logic [IW-1:0]    rd_idx;

  logic                              accept;
  logic [IW-1:0]                     idx;
  logic                              issue;
  logic                              wr_en;
  apq_pkg::slot_t                    wr_slot;
  apq_pkg::slot_t                    rd_slot;
  apq_pkg::best_ctl_t                ctl;
  logic [IW-1:0]                     best_idx;
  logic signed [apq_pkg::ITEM_W-1:0] best_item;

  always_comb begin
    in_stall     = (state != S_IDLE);
    accept       = in_valid && !in_stall;
    idx          = cnt[IW-1:0];
    issue        = (state == S_SCAN) && (cnt != FULL);
    wr_en        = (state == S_FREE) && !slot_valid[idx];
    wr_slot.prio = req.priority_req;
    wr_slot.item = req.item_in;
    ctl.clr      = accept;
    ctl.cmp      = rd_pend;
  end

  apq_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (wr_slot),
    .raddr (idx),
    .rdata (rd_slot)
  );

  apq_best #(.IW(IW)) u_best (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .vld       (rd_vld),
    .idx       (rd_idx),
    .ent       (rd_slot),
    .best_idx  (best_idx),
    .best_item (best_item)
  );

  // read pipeline tags travel with the registered memory data
  always_ff @(posedge clk) begin
    rd_vld <= slot_valid[idx];
    rd_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      slot_valid  <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend <= issue;
      // in S_DONE the output register is handled below
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            cnt <= '0;
            priority if (in_data.op == apq_pkg::OP_INSERT) begin
              if (entry_count == FULL) begin
                res   <= '{item_out: '0, status: apq_pkg::ST_OVERFLOW};
                state <= S_DONE;
              end else begin
                state <= S_FREE;
              end
            end else if (in_data.op == apq_pkg::OP_REMOVE ||
                         in_data.op == apq_pkg::OP_PEEK) begin
              if (entry_count == '0) begin
                res   <= '{item_out: '0, status: apq_pkg::ST_UNDERFLOW};
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              res   <= '{item_out: '0, status: apq_pkg::ST_OK};
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] <= 1'b1;
            entry_count     <= entry_count + CW'(1);
            res             <= '{item_out: '0, status: apq_pkg::ST_OK};
            state           <= S_DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end else if (!rd_pend) begin
            res <= '{item_out: best_item, status: apq_pkg::ST_OK};
            if (req.op == apq_pkg::OP_REMOVE) begin
              slot_valid[best_idx] <= 1'b0;
              entry_count          <= entry_count - CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL)
    else $error("entry count above slot count");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    entry_count == CW'($countones(slot_valid)))
    else $error("entry count differs from valid bits");

  a_free_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_FREE |-> entry_count != FULL)
    else $error("free-slot search on a full table");

  a_scan_not_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> entry_count != '0)
    else $error("maximum scan on an empty table");
`endif

endmodule

@@ rtl/apq_mem.sv @@
module apq_mem #(
  parameter int SLOTS = apq_pkg::SLOTS_DEF,
  parameter int IW    = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  apq_pkg::slot_t wdata,
  input  logic [IW-1:0]  raddr,
  output apq_pkg::slot_t rdata
);

  apq_pkg::slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/apq_best.sv @@
module apq_best #(
  parameter int IW = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  apq_pkg::best_ctl_t                 ctl,
  input  logic                               vld,
  input  logic [IW-1:0]                      idx,
  input  apq_pkg::slot_t                     ent,
  output logic [IW-1:0]                      best_idx,
  output logic signed [apq_pkg::ITEM_W-1:0]  best_item
);

  logic                       have;
  logic [apq_pkg::PRIO_W-1:0] best_prio;
  logic                       take;

  // strictly greater keeps the lowest index on ties, slots arrive in order
  assign take = ctl.cmp && vld && (!have || (ent.prio > best_prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clr) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_prio <= ent.prio;
      best_idx  <= idx;
      best_item <= ent.item;
    end
  end

endmodule

@@ verif/apq_checker.sv @@
module apq_checker #(
  parameter int SLOTS = apq_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  apq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  apq_pkg::out_t out_data,
  output int            fails,
  output int            pending,
  output int            overflows,
  output int            underflows
);

  // shadow copy of the slot table
  logic                              slot_used [SLOTS];
  logic [apq_pkg::PRIO_W-1:0]        slot_prio [SLOTS];
  logic signed [apq_pkg::ITEM_W-1:0] slot_val  [SLOTS];
  int                                held;
  apq_pkg::out_t                     due_results [$];
  int                                err_count;
  int                                full_hits;
  int                                empty_hits;

  function automatic apq_pkg::out_t serve_request(input apq_pkg::in_t req);
    apq_pkg::out_t res;
    int            pick;
    res        = '0;
    res.status = apq_pkg::ST_OK;
    pick       = SLOTS;
    unique case (req.op)
      apq_pkg::OP_INSERT: begin
        for (int i = 0; i < SLOTS; i++)
          if (!slot_used[i] && pick == SLOTS) pick = i;
        if (held >= SLOTS || pick == SLOTS) begin
          res.status = apq_pkg::ST_OVERFLOW;
        end else begin
          slot_used[pick] = 1'b1;
          slot_prio[pick] = req.priority_req;
          slot_val[pick]  = req.item_in;
          held++;
        end
      end
      apq_pkg::OP_REMOVE, apq_pkg::OP_PEEK: begin
        // strict greater-than keeps the lowest index on ties
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && (pick == SLOTS || slot_prio[i] > slot_prio[pick])) pick = i;
        if (held == 0 || pick == SLOTS) begin
          res.status = apq_pkg::ST_UNDERFLOW;
        end else begin
          res.item_out = slot_val[pick];
          if (req.op == apq_pkg::OP_REMOVE) begin
            slot_used[pick] = 1'b0;
            held--;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    apq_pkg::out_t want;
    apq_pkg::out_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      held = 0;
      due_results.delete();
      err_count  = 0;
      full_hits  = 0;
      empty_hits = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = serve_request(in_data);
        if (want.status == apq_pkg::ST_OVERFLOW) full_hits++;
        if (want.status == apq_pkg::ST_UNDERFLOW) empty_hits++;
        due_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item_out %0d status %0d", $time,
                   got.item_out, got.status);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (got.item_out !== want.item_out) begin
            $display("%0t: item_out expected %0d got %0d", $time, want.item_out,
                     got.item_out);
            err_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            err_count++;
          end
        end
      end
    end
    fails      <= err_count;
    pending    <= due_results.size();
    overflows  <= full_hits;
    underflows <= empty_hits;
  end

endmodule

@@ verif/testbench.sv @@
module testbench;

  localparam int SLOTS = apq_pkg::SLOTS_DEF;
  localparam int ITEMS = 1950;
  localparam int LIMIT = 1_000_000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // traffic shapes for the random blocks
  localparam int MODE_FILL_ALL  = 0;
  localparam int MODE_EMPTY_ALL = 1;
  localparam int MODE_FILL      = 2;
  localparam int MODE_EMPTY     = 3;
  localparam int MODE_MIXED     = 4;
  localparam int MODE_NOISE     = 5;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  apq_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall = 1'b0;
  apq_pkg::out_t out_data;

  int   fails;
  int   pending;
  int   overflows;
  int   underflows;
  int   cycles = 0;
  int   stall_left;
  logic calm;
  int   sent_ops [4];

  array_priority_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  apq_checker #(.SLOTS(SLOTS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .pending   (pending),
    .overflows (overflows),
    .underflows(underflows)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("array_priority_queue_unit test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= idle_len();
    end
  end

  function automatic apq_pkg::in_t item_of(input logic [1:0] op,
                                           input logic [apq_pkg::PRIO_W-1:0] prio,
                                           input logic signed [apq_pkg::ITEM_W-1:0] val);
    apq_pkg::in_t r;
    r.op           = op;
    r.priority_req = prio;
    r.item_in      = val;
    return r;
  endfunction

  // narrow priority ranges give plenty of ties
  function automatic apq_pkg::in_t random_req(input logic [1:0] op);
    apq_pkg::in_t r;
    int           sel;
    logic [31:0]  rnd;
    r.op      = op;
    r.item_in = $urandom;
    sel       = $urandom_range(0, 9);
    if (sel < 3)
      rnd = $urandom_range(0, 3);
    else
      rnd = $urandom;
    if (sel == 3)
      r.priority_req = ($urandom_range(0, 1) == 1) ? '1 : '0;
    else
      r.priority_req = rnd[apq_pkg::PRIO_W-1:0];
    return r;
  endfunction

  function automatic logic [1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    unique case (mode)
      MODE_FILL_ALL:  return apq_pkg::OP_INSERT;
      MODE_EMPTY_ALL: return apq_pkg::OP_REMOVE;
      MODE_FILL:      return (r < 80) ? apq_pkg::OP_INSERT :
                             (r < 92) ? apq_pkg::OP_REMOVE : apq_pkg::OP_PEEK;
      MODE_EMPTY:     return (r < 20) ? apq_pkg::OP_INSERT :
                             (r < 80) ? apq_pkg::OP_REMOVE : apq_pkg::OP_PEEK;
      MODE_MIXED:     return (r < 45) ? apq_pkg::OP_INSERT :
                             (r < 80) ? apq_pkg::OP_REMOVE : apq_pkg::OP_PEEK;
      default:        return 2'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_item(input apq_pkg::in_t req);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    sent_ops[req.op]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // first edge lets the checker see the last accepted item
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    int len;
    int blk;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused code, extremes, ties across slots, refill of a freed slot
    send_item(item_of(apq_pkg::OP_PEEK, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '1, '1));
    send_item(item_of(OP_UNUSED, '1, '1));
    send_item(item_of(apq_pkg::OP_INSERT, '0, 32'sh8000_0000));
    send_item(item_of(apq_pkg::OP_INSERT, '1, 32'sh7fff_ffff));
    send_item(item_of(apq_pkg::OP_INSERT, '1, -32'sd1));
    send_item(item_of(apq_pkg::OP_INSERT, 16'h8000, '0));
    send_item(item_of(apq_pkg::OP_PEEK, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_PEEK, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_INSERT, 16'h0001, 32'sh5a5a_5a5a));
    send_item(item_of(apq_pkg::OP_INSERT, 16'h8000, 32'sh1234_5678));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(OP_UNUSED, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_REMOVE, '0, '0));
    send_item(item_of(apq_pkg::OP_PEEK, '0, '0));
    in_valid <= 1'b0;
    settle();

    blk = 0;
    while (sent_ops[apq_pkg::OP_INSERT] + sent_ops[apq_pkg::OP_REMOVE] +
           sent_ops[apq_pkg::OP_PEEK] + sent_ops[OP_UNUSED] < ITEMS) begin
      // open with a full fill past overflow and a full drain past underflow
      if (blk == 0)
        mode = MODE_FILL_ALL;
      else if (blk == 1)
        mode = MODE_EMPTY_ALL;
      else
        mode = $urandom_range(MODE_FILL, MODE_NOISE);
      len = (blk < 2) ? SLOTS + 4 : $urandom_range(8, 60);
      calm <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) send_item(random_req(pick_op(mode)));
      if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        settle();
      end
      blk++;
    end

    in_valid <= 1'b0;
    settle();
    repeat (SLOTS + 4) @(posedge clk);

    $display("sent %0d inserts, %0d removes, %0d peeks and %0d unused op codes",
             sent_ops[apq_pkg::OP_INSERT], sent_ops[apq_pkg::OP_REMOVE],
             sent_ops[apq_pkg::OP_PEEK], sent_ops[OP_UNUSED]);
    $display("table hit full %0d times and empty %0d times", overflows, underflows);
    if (fails == 0)
      $display("array_priority_queue_unit test passed");
    else
      $display("array_priority_queue_unit test failed");
    $finish;
  end

endmodule

@@ array_priority_queue_unit.f @@
rtl/apq_pkg.sv
rtl/apq_mem.sv
rtl/apq_best.sv
rtl/array_priority_queue_unit.sv
verif/apq_checker.sv
verif/testbench.sv
